[design/dtmf_event_to_tone_segmenter_defines.svh]
// Assertion macros used by the checker file of the tone segmenter.
// Depends on nothing; include it by its bare file name.
`ifndef DTMF_EVENT_TO_TONE_SEGMENTER_DEFINES_SVH
`define DTMF_EVENT_TO_TONE_SEGMENTER_DEFINES_SVH

// When the antecedent holds at an edge, the consequent holds at the same edge.
`define DTMF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// When the antecedent holds at an edge, the consequent holds at the next edge.
`define DTMF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

[design/dtmf_seg_pkg.sv]
// Shared types, status codes and DTMF frequency tables of the tone segmenter.
// Depends on nothing.
`timescale 1ns / 1ps

package dtmf_seg_pkg;

    localparam int TS_W   = 64;
    localparam int DUR_W  = 16;
    localparam int VOL_W  = 6;
    localparam int CODE_W = 8;
    localparam int STAT_W = 2;
    localparam int COL_W  = 11;
    localparam int ROW_W  = 10;

    localparam logic [STAT_W-1:0] STATUS_VALID         = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_REDUNDANT_END = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_UNKNOWN_EVENT = 2'd2;

    typedef struct packed {
        logic              marker_bit;
        logic              end_bit;
        logic [TS_W-1:0]   event_timestamp;
        logic [DUR_W-1:0]  event_duration;
        logic [VOL_W-1:0]  event_volume;
        logic [CODE_W-1:0] event_code;
    } item_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              marker_out;
        logic [VOL_W-1:0]  volume_out;
        logic [DUR_W-1:0]  segment_duration;
        logic [TS_W-1:0]   segment_timestamp;
        logic [COL_W-1:0]  column_freq_hz;
        logic [ROW_W-1:0]  row_freq_hz;
    } result_t;

    typedef struct packed {
        logic [TS_W-1:0]  current_timestamp;
        logic [DUR_W-1:0] sent_duration;
        logic             end_already_sent;
    } track_t;

    // High-group (column) frequency of a DTMF key.
    function automatic logic [COL_W-1:0] column_freq(input logic [3:0] code);
        logic [COL_W-1:0] f;
        case (code) inside
            4'd1, 4'd4, 4'd7, 4'd10:  f = 11'd1209;
            4'd0, 4'd2, 4'd5, 4'd8:   f = 11'd1336;
            4'd3, 4'd6, 4'd9, 4'd11:  f = 11'd1477;
            default:                  f = 11'd1633;
        endcase
        return f;
    endfunction

    // Low-group (row) frequency of a DTMF key.
    function automatic logic [ROW_W-1:0] row_freq(input logic [3:0] code);
        logic [ROW_W-1:0] f;
        case (code) inside
            4'd1, 4'd2, 4'd3, 4'd12:  f = 10'd697;
            4'd4, 4'd5, 4'd6, 4'd13:  f = 10'd770;
            4'd7, 4'd8, 4'd9, 4'd14:  f = 10'd852;
            default:                  f = 10'd941;
        endcase
        return f;
    endfunction

endpackage

[design/dtmf_seg_calc.sv]
// Combinational segment builder: classifies one packet, forms its result and
// the next event-tracking state. Depends on dtmf_seg_pkg.
`timescale 1ns / 1ps

module dtmf_seg_calc (
    input  dtmf_seg_pkg::item_t   item,
    input  dtmf_seg_pkg::track_t  track,
    output dtmf_seg_pkg::result_t result,
    output dtmf_seg_pkg::track_t  track_next
);

    logic                          same_ts;
    logic                          redundant_end;
    logic                          unknown_code;
    logic [dtmf_seg_pkg::DUR_W-1:0] sent_eff;

    assign same_ts       = (item.event_timestamp == track.current_timestamp);
    assign redundant_end = item.end_bit && same_ts && track.end_already_sent;
    assign unknown_code  = (item.event_code[dtmf_seg_pkg::CODE_W-1:4] != '0);

    // A new timestamp starts a fresh event, so nothing of it has been sent yet.
    assign sent_eff = same_ts ? track.sent_duration : '0;

    always_comb
    begin
        result     = '0;
        track_next = track;
        if (redundant_end)
        begin
            result.status = dtmf_seg_pkg::STATUS_REDUNDANT_END;
        end
        else if (unknown_code)
        begin
            result.status = dtmf_seg_pkg::STATUS_UNKNOWN_EVENT;
        end
        else
        begin
            result.status            = dtmf_seg_pkg::STATUS_VALID;
            result.marker_out        = item.marker_bit;
            result.volume_out        = item.event_volume;
            result.segment_duration  = item.event_duration - sent_eff;
            result.segment_timestamp = item.event_timestamp
                + {{(dtmf_seg_pkg::TS_W-dtmf_seg_pkg::DUR_W){1'b0}}, sent_eff};
            result.column_freq_hz    = dtmf_seg_pkg::column_freq(item.event_code[3:0]);
            result.row_freq_hz       = dtmf_seg_pkg::row_freq(item.event_code[3:0]);
            track_next.current_timestamp = item.event_timestamp;
            track_next.sent_duration     = item.event_duration;
            track_next.end_already_sent  = item.end_bit;
        end
    end

endmodule

[design/dtmf_event_to_tone_segmenter.sv]
// Top level of the telephone-event to DTMF tone segmenter.
// Depends on dtmf_seg_pkg and dtmf_seg_calc.
`timescale 1ns / 1ps

// The segmenter takes one telephone-event packet per transfer and returns one
// result per packet, in order, through the input and result registers. It
// sustains one packet per clock cycle unless the output side stalls: the
// figure is set by the event-tracking registers (timestamp, duration already
// sent, end flag), which are read and rewritten in the single cycle in which a
// packet moves from the input register into the result register, through one
// 64-bit compare and one 64-bit add. A result with status zero carries the
// DTMF column and row frequencies, the part of the cumulative duration not
// yet sent and the timestamp at which that part starts. A repeated end packet
// of the same event returns status one, a code above 15 returns status two;
// both leave the tracking state untouched and carry zero in every other
// field. The input side stalls only while its register holds a packet and the
// result register holds a result that the output side is stalling.

module dtmf_event_to_tone_segmenter (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                event_valid,
    output logic                                event_stall,
    input  logic                                marker_bit,
    input  logic                                end_bit,
    input  logic [dtmf_seg_pkg::TS_W-1:0]       event_timestamp,
    input  logic [dtmf_seg_pkg::DUR_W-1:0]      event_duration,
    input  logic [dtmf_seg_pkg::VOL_W-1:0]      event_volume,
    input  logic [dtmf_seg_pkg::CODE_W-1:0]     event_code,

    output logic                                segment_valid,
    input  logic                                segment_stall,
    output logic [dtmf_seg_pkg::STAT_W-1:0]     status,
    output logic                                marker_out,
    output logic [dtmf_seg_pkg::VOL_W-1:0]      volume_out,
    output logic [dtmf_seg_pkg::DUR_W-1:0]      segment_duration,
    output logic [dtmf_seg_pkg::TS_W-1:0]       segment_timestamp,
    output logic [dtmf_seg_pkg::COL_W-1:0]      column_freq_hz,
    output logic [dtmf_seg_pkg::ROW_W-1:0]      row_freq_hz
);

    // Input register: holds the packet being worked on.
    dtmf_seg_pkg::item_t   item_reg;
    logic                  item_valid_reg;

    // Event tracking state, advanced by each packet that yields a valid result.
    dtmf_seg_pkg::track_t  track_reg;
    dtmf_seg_pkg::track_t  track_next;

    // Result register facing the output channel.
    dtmf_seg_pkg::result_t result_reg;
    dtmf_seg_pkg::result_t result_next;
    logic                  result_valid_reg;

    logic                  out_free;
    logic                  move;
    logic                  take;

    // The result register can be loaded when it is empty or being drained.
    assign out_free    = !result_valid_reg || !segment_stall;
    assign move        = item_valid_reg && out_free;
    assign event_stall = item_valid_reg && !out_free;
    assign take        = event_valid && !event_stall;

    dtmf_seg_calc u_calc (
        .item       (item_reg),
        .track      (track_reg),
        .result     (result_next),
        .track_next (track_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            track_reg        <= '0;
        end
        else
        begin
            if (take)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (move)
            begin
                item_valid_reg <= 1'b0;
            end

            if (move)
            begin
                result_valid_reg <= 1'b1;
                track_reg        <= track_next;
            end
            else if (!segment_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset; their valid bits qualify them.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.marker_bit      <= marker_bit;
            item_reg.end_bit         <= end_bit;
            item_reg.event_timestamp <= event_timestamp;
            item_reg.event_duration  <= event_duration;
            item_reg.event_volume    <= event_volume;
            item_reg.event_code      <= event_code;
        end
        if (move)
        begin
            result_reg <= result_next;
        end
    end

    assign segment_valid     = result_valid_reg;
    assign status            = result_reg.status;
    assign marker_out        = result_reg.marker_out;
    assign volume_out        = result_reg.volume_out;
    assign segment_duration  = result_reg.segment_duration;
    assign segment_timestamp = result_reg.segment_timestamp;
    assign column_freq_hz    = result_reg.column_freq_hz;
    assign row_freq_hz       = result_reg.row_freq_hz;

endmodule

[design/dtmf_seg_checker.sv]
// Port-level checker of the tone segmenter and its bind to the top level.
// Depends on dtmf_seg_pkg and dtmf_event_to_tone_segmenter_defines.svh.
`timescale 1ns / 1ps
`include "dtmf_event_to_tone_segmenter_defines.svh"

module dtmf_seg_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             event_stall,
    input logic                             segment_valid,
    input logic                             segment_stall,
    input logic [dtmf_seg_pkg::STAT_W-1:0]  status,
    input logic                             marker_out,
    input logic [dtmf_seg_pkg::VOL_W-1:0]   volume_out,
    input logic [dtmf_seg_pkg::DUR_W-1:0]   segment_duration,
    input logic [dtmf_seg_pkg::TS_W-1:0]    segment_timestamp,
    input logic [dtmf_seg_pkg::COL_W-1:0]   column_freq_hz,
    input logic [dtmf_seg_pkg::ROW_W-1:0]   row_freq_hz
);

    logic dropped;
    logic fields_zero;

    assign dropped = (status == dtmf_seg_pkg::STATUS_REDUNDANT_END)
                  || (status == dtmf_seg_pkg::STATUS_UNKNOWN_EVENT);
    assign fields_zero = !marker_out && (volume_out == '0) && (segment_duration == '0)
                      && (segment_timestamp == '0) && (column_freq_hz == '0)
                      && (row_freq_hz == '0);

    // A held result stays offered.
    `DTMF_ASSERT_NEXT(a_result_held, clk, rst_n, segment_valid && segment_stall, segment_valid)

    // The input side is only held back by a blocked result.
    `DTMF_ASSERT_SAME(a_stall_cause, clk, rst_n, event_stall, segment_valid && segment_stall)

    // A dropped packet carries nothing but its status.
    `DTMF_ASSERT_SAME(a_drop_zero, clk, rst_n, segment_valid && dropped, fields_zero)

    // A valid segment always names a real key.
    `DTMF_ASSERT_SAME(a_tone_freqs, clk, rst_n,
        segment_valid && (status == dtmf_seg_pkg::STATUS_VALID),
        (column_freq_hz >= 11'd1209) && (row_freq_hz >= 10'd697))

endmodule

bind dtmf_event_to_tone_segmenter dtmf_seg_checker u_dtmf_seg_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .event_stall       (event_stall),
    .segment_valid     (segment_valid),
    .segment_stall     (segment_stall),
    .status            (status),
    .marker_out        (marker_out),
    .volume_out        (volume_out),
    .segment_duration  (segment_duration),
    .segment_timestamp (segment_timestamp),
    .column_freq_hz    (column_freq_hz),
    .row_freq_hz       (row_freq_hz)
);
